FILE: design/efm_pkg.sv
// efm_pkg: shared types and constants of the windowed edge frequency monitor
// no dependencies; imported by every design file of the block
package efm_pkg;

   // configuration register width and index port width
   localparam int CFG_W       = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int OUT_W       = 16;

   // stream payload widths (whole bytes)
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LIMIT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_EDGE_LIMIT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_EDGE_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STABLE_WINDOWS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_EDGE_SCALE      = 3'd4;

   // register reset values
   localparam logic [CFG_W-1:0] RST_WINDOW_LIMIT    = 16'h01F3;
   localparam logic [CFG_W-1:0] RST_LOW_EDGE_LIMIT  = 16'd4;
   localparam logic [CFG_W-1:0] RST_HIGH_EDGE_LIMIT = 16'd7;
   localparam logic [CFG_W-1:0] RST_STABLE_WINDOWS  = 16'h004F;
   localparam logic [CFG_W-1:0] RST_EDGE_SCALE      = 16'h0096;

   // configuration bundle
   typedef struct packed {
      logic [CFG_W-1:0] window_limit;
      logic [CFG_W-1:0] low_edge_limit;
      logic [CFG_W-1:0] high_edge_limit;
      logic [CFG_W-1:0] stable_windows;
      logic [CFG_W-1:0] edge_scale;
   } efm_cfg_type;

   // one input item
   typedef struct packed {
      logic gate_bit;
      logic run_state;
      logic sample_bit;
   } efm_item_type;

   // one result item
   typedef struct packed {
      logic             stable_flag;
      logic [OUT_W-1:0] scaled_value;
      logic [OUT_W-1:0] edges_in_window;
   } efm_result_type;

endpackage

FILE: design/windowed_edge_frequency_monitor.sv
// windowed_edge_frequency_monitor: top level with input register, counter core and
// result register; depends on efm_pkg, efm_csr and efm_core
//
//  channel  dir  handshake               payload
//  req_     in   req_tvalid/req_tready   req_tdata  {gate_bit, run_state, sample_bit}
//  rsp_     out  rsp_tvalid/rsp_tready   rsp_tdata  {stable_flag, scaled_value, edges}
//  csr_     in   csr_wen                 csr_index, csr_wdata
//
// one item per cycle unless a held result stalls a window-end item; an item is
// held in the input register, then a window-end item loads the result register
// a result is produced only at a window end; other items leave no result
// reset is synchronous and clears counters, valid flags and configuration registers to defaults
// a held result stalls only items that end a window
module windowed_edge_frequency_monitor #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [0] sample_bit, [1] run_state, [2] gate_bit, [7:3] zero
   input  logic [efm_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] edges_in_window, [31:16] scaled_value, [32] stable_flag, [39:33] zero
   output logic [efm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_wen,
   input  logic [efm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [efm_pkg::CFG_W-1:0]       csr_wdata
);
   import efm_pkg::*;

   efm_cfg_type    cfg;
   efm_item_type   item_ff;
   logic           in_valid_ff;
   logic           core_step;
   logic           window_end;
   efm_result_type core_result;
   efm_result_type rsp_ff;
   logic           rsp_valid_ff;
   logic           rsp_load;

   efm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   efm_core #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (core_step),
      .item       (item_ff),
      .cfg        (cfg),
      .window_end (window_end),
      .result     (core_result)
   );

   // held item moves on unless it ends a window and the result slot is blocked
   assign core_step  = in_valid_ff && (!window_end || !rsp_valid_ff || rsp_tready);
   assign rsp_load   = core_step && window_end;
   assign req_tready = !in_valid_ff || core_step;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.sample_bit <= req_tdata[0];
         item_ff.run_state  <= req_tdata[1];
         item_ff.gate_bit   <= req_tdata[2];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2*OUT_W - 1){1'b0}}, rsp_ff.stable_flag,
                        rsp_ff.scaled_value, rsp_ff.edges_in_window};

`ifndef SYNTHESIS
   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !rsp_load)
      else $error("result register overwritten while stalled");

   // a held item that did not step stays in the input register unchanged
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !core_step) |=> (in_valid_ff && $stable(item_ff)))
      else $error("input item lost while core stalled");

   // a stall of the core only happens when a window ends into a full result slot
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !core_step) |-> (window_end && rsp_valid_ff))
      else $error("core stalled without a blocked result");
`endif

endmodule

FILE: design/efm_csr.sv
// efm_csr: configuration registers of the edge frequency monitor
// depends on efm_pkg for register indexes, reset values and the cfg struct
module efm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [efm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [efm_pkg::CFG_W-1:0]     csr_wdata,
   output efm_pkg::efm_cfg_type          cfg
);
   import efm_pkg::*;

   efm_cfg_type cfg_ff;
   efm_cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_WINDOW_LIMIT:    cfg_in.window_limit    = csr_wdata;
            CSR_LOW_EDGE_LIMIT:  cfg_in.low_edge_limit  = csr_wdata;
            CSR_HIGH_EDGE_LIMIT: cfg_in.high_edge_limit = csr_wdata;
            CSR_STABLE_WINDOWS:  cfg_in.stable_windows  = csr_wdata;
            CSR_EDGE_SCALE:      cfg_in.edge_scale      = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_limit    <= RST_WINDOW_LIMIT;
         cfg_ff.low_edge_limit  <= RST_LOW_EDGE_LIMIT;
         cfg_ff.high_edge_limit <= RST_HIGH_EDGE_LIMIT;
         cfg_ff.stable_windows  <= RST_STABLE_WINDOWS;
         cfg_ff.edge_scale      <= RST_EDGE_SCALE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/efm_core.sv
// efm_core: edge, tick and quiet-window counters with the per-item window logic
// depends on efm_pkg for the item, result and cfg structs
module efm_core #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  efm_pkg::efm_item_type   item,
   input  efm_pkg::efm_cfg_type    cfg,
   output logic                    window_end,
   output efm_pkg::efm_result_type result
);
   import efm_pkg::*;

   localparam int CMP_W = (COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W;
   localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};
   localparam logic [CMP_W-1:0] OUT_MAX_X = CMP_W'({OUT_W{1'b1}});

   logic                     last_level_ff;
   logic [COUNTER_WIDTH-1:0] edge_ff, edge_in;
   logic [COUNTER_WIDTH-1:0] tick_ff, tick_in;
   logic [COUNTER_WIDTH-1:0] quiet_ff, quiet_in;
   logic                     flag_ff, flag_in;

   logic [COUNTER_WIDTH-1:0] edge_next;
   logic [COUNTER_WIDTH-1:0] tick_next;
   logic [COUNTER_WIDTH-1:0] quiet_next;
   logic [COUNTER_WIDTH-1:0] quiet_inc;
   logic [CMP_W-1:0]         edge_x;
   logic [CMP_W-1:0]         tick_x;
   logic [CMP_W-1:0]         quiet_inc_x;
   logic [OUT_W-1:0]         edge_lo;

   // edge and tick counting with saturation
   always_comb begin
      edge_next = edge_ff;
      if (item.sample_bit != last_level_ff) begin
         edge_next = (edge_ff == CNT_MAX) ? CNT_MAX : edge_ff + 1'b1;
      end
      tick_next  = (tick_ff == CNT_MAX) ? CNT_MAX : tick_ff + 1'b1;
      edge_x     = CMP_W'(edge_next);
      tick_x     = CMP_W'(tick_next);
      window_end = (tick_x > CMP_W'(cfg.window_limit)) || (tick_next == CNT_MAX);
   end

   // quiet-window count and stable flag at window end
   always_comb begin
      quiet_next = quiet_ff;
      flag_in    = flag_ff;
      if (item.run_state) begin
         if (!item.gate_bit) begin
            quiet_next = '0;
         end
      end
      quiet_inc   = (quiet_next == CNT_MAX) ? CNT_MAX : quiet_next + 1'b1;
      quiet_inc_x = CMP_W'(quiet_inc);
      if (item.run_state) begin
         if (edge_x <= CMP_W'(cfg.low_edge_limit)) begin
            quiet_next = quiet_inc;
            if (quiet_inc_x >= CMP_W'(cfg.stable_windows)) begin
               flag_in = 1'b1;
            end
         end else if (edge_x > CMP_W'(cfg.high_edge_limit)) begin
            quiet_next = '0;
            flag_in    = 1'b0;
         end
      end else begin
         quiet_next = '0;
      end
   end

   // next state on each stepped item
   always_comb begin
      edge_in  = edge_ff;
      tick_in  = tick_ff;
      quiet_in = quiet_ff;
      if (step) begin
         edge_in = window_end ? '0 : edge_next;
         tick_in = window_end ? '0 : tick_next;
         if (window_end) begin
            quiet_in = quiet_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= 1'b0;
         edge_ff       <= '0;
         tick_ff       <= '0;
         quiet_ff      <= '0;
         flag_ff       <= 1'b0;
      end else begin
         if (step) begin
            last_level_ff <= item.sample_bit;
         end
         edge_ff  <= edge_in;
         tick_ff  <= tick_in;
         quiet_ff <= quiet_in;
         if (step && window_end) begin
            flag_ff <= flag_in;
         end
      end
   end

   // result fields: saturated count and low half of the scaled product
   always_comb begin
      edge_lo                = edge_x[OUT_W-1:0];
      result.edges_in_window = (edge_x > OUT_MAX_X) ? {OUT_W{1'b1}} : edge_lo;
      result.scaled_value    = edge_lo * cfg.edge_scale;
      result.stable_flag     = flag_in;
   end

endmodule
